// ----- rtl/core/complex_arith_unit_defines.svh -----
// Assertion macros shared by the complex arithmetic unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// Implication check, disabled during reset.
`define CAU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check, disabled during reset.
`define CAU_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/cau_pkg.sv -----
// Package for the complex arithmetic unit: command codes and fixed widths.
// No dependencies.
`default_nettype none
package cau_pkg;
    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MOD = 3'd4
    } cmd_t;
    localparam int CMD_W = 3;
endpackage
`default_nettype wire

// ----- rtl/core/cau_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage, unsigned.
// Depends on nothing; used by complex_arith_unit.
`default_nettype none
module cau_divider #(
    parameter int NW = 48,
    parameter int DW = 33,
    parameter int TW = 8
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [TW-1:0] tag_in,
    output logic [NW-1:0]      quo,
    output logic [TW-1:0]      tag_out
);
    logic [NW-1:0] q_reg [0:NW];
    logic [DW:0]   r_reg [0:NW];
    logic [DW-1:0] d_reg [0:NW];
    logic [TW-1:0] t_reg [0:NW];

    always_comb begin
        q_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
        t_reg[0] = tag_in;
    end

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DW+1:0] trial;
        logic [DW+1:0] sh;
        logic [NW-1:0] q_next;
        always_comb begin
            sh    = {r_reg[i], q_reg[i][NW-1-i]};
            trial = sh - {2'b00, d_reg[i]};
            // numerator bit is consumed and replaced by the quotient bit
            q_next             = q_reg[i];
            q_next[NW-1-i]     = ~trial[DW+1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i+1] <= q_next;
                r_reg[i+1] <= trial[DW+1] ? sh[DW:0] : trial[DW:0];
                d_reg[i+1] <= d_reg[i];
                t_reg[i+1] <= t_reg[i];
            end
        end
    end

    assign quo     = q_reg[NW];
    assign tag_out = t_reg[NW];
endmodule
`default_nettype wire

// ----- rtl/core/complex_arith_unit.sv -----
// Complex ALU top level: add, subtract, multiply, divide, modulus, saturating.
// Depends on cau_pkg, cau_divider and complex_arith_unit_defines.svh.
// Every command passes the same stages: products, sums, the pipelined divider
// stages (the 2-bit-per-stage square root is padded to match) and the output register.
// Throughput: one item per cycle when not stalled; the whole pipe advances when the output
// register is empty or being taken. Synchronous active-low reset clears valids.
`default_nettype none
`include "complex_arith_unit_defines.svh"
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // a_re, a_im, b_re, b_im (low to high)
    input  wire logic [4*DATA_WIDTH-1:0] s_tdata,
    // command
    input  wire logic [CMD_W-1:0]        s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // res_re, res_im (low to high)
    output logic [2*DATA_WIDTH-1:0]      m_tdata,
    // overflow, div_by_zero (low to high)
    output logic [1:0]                   m_tuser
);
    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2*W + 2;             // products sum/difference
    localparam int NW  = 2*W + 1 + FRAC_BITS; // divider numerator magnitude
    localparam int DNW = 2*W + 1;             // |b|^2
    localparam int SQW = 2*W + 2;             // even width for root
    localparam int RS  = SQW/2;               // root stages
    localparam logic signed [PW+FRAC_BITS-1:0] MAXV = (PW+FRAC_BITS)'((64'sd1 <<< (W-1)) - 1);
    localparam logic signed [PW+FRAC_BITS-1:0] MINV = -MAXV - 1;

    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // stage 1: products
    logic               v1_reg;
    logic [CMD_W-1:0]   c1_reg;
    logic signed [W-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [2*W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [2*W-1:0] p_bb_r_reg, p_bb_i_reg, p_aa_r_reg, p_aa_i_reg;
    logic signed [W-1:0] ar, ai, br, bi;
    assign ar = s_tdata[W-1:0];
    assign ai = s_tdata[2*W-1:W];
    assign br = s_tdata[3*W-1:2*W];
    assign bi = s_tdata[4*W-1:3*W];

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_tvalid;
        if (adv) begin
            c1_reg <= s_tuser;
            ar1_reg <= ar; ai1_reg <= ai; br1_reg <= br; bi1_reg <= bi;
            p_rr_reg <= ar*br; p_ii_reg <= ai*bi;
            p_ri_reg <= ar*bi; p_ir_reg <= ai*br;
            p_bb_r_reg <= br*br; p_bb_i_reg <= bi*bi;
            p_aa_r_reg <= ar*ar; p_aa_i_reg <= ai*ai;
        end
    end

    // stage 2: sums, divider operand prep
    logic v2_reg;
    logic [CMD_W-1:0] c2_reg;
    logic signed [PW-1:0] s_re_reg, s_im_reg;     // add/sub/mul pre-shift
    logic signed [PW-1:0] n_re_reg, n_im_reg;
    logic [DNW-1:0] den_reg;
    logic [SQW-1:0] sq_reg;
    logic signed [PW-1:0] sre_next, sim_next;

    always_comb begin
        sre_next = '0;
        sim_next = '0;
        case (cmd_t'(c1_reg))
            CMD_ADD: begin
                sre_next = PW'(ar1_reg) + PW'(br1_reg);
                sim_next = PW'(ai1_reg) + PW'(bi1_reg);
            end
            CMD_SUB: begin
                sre_next = PW'(ar1_reg) - PW'(br1_reg);
                sim_next = PW'(ai1_reg) - PW'(bi1_reg);
            end
            CMD_MUL: begin
                sre_next = PW'(p_rr_reg) - PW'(p_ii_reg);
                sim_next = PW'(p_ri_reg) + PW'(p_ir_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            c2_reg   <= c1_reg;
            s_re_reg <= sre_next;
            s_im_reg <= sim_next;
            n_re_reg <= PW'(p_rr_reg) + PW'(p_ii_reg);
            n_im_reg <= PW'(p_ir_reg) - PW'(p_ri_reg);
            den_reg  <= DNW'($unsigned(p_bb_r_reg)) + DNW'($unsigned(p_bb_i_reg));
            sq_reg   <= SQW'($unsigned(p_aa_r_reg)) + SQW'($unsigned(p_aa_i_reg));
        end
    end

    // divider inputs: magnitudes, sign travels in tag
    logic [NW-1:0] mag_re, mag_im;
    assign mag_re = NW'(n_re_reg[PW-1] ? -n_re_reg : n_re_reg) << FRAC_BITS;
    assign mag_im = NW'(n_im_reg[PW-1] ? -n_im_reg : n_im_reg) << FRAC_BITS;

    logic [NW-1:0] q_re, q_im;
    logic [1:0] sgn_q;
    cau_divider #(.NW(NW), .DW(DNW), .TW(1)) u_div_re (
        .aclk(aclk), .en(adv), .num(mag_re), .den(den_reg),
        .tag_in(n_re_reg[PW-1]), .quo(q_re), .tag_out(sgn_q[0]));
    cau_divider #(.NW(NW), .DW(DNW), .TW(1)) u_div_im (
        .aclk(aclk), .en(adv), .num(mag_im), .den(den_reg),
        .tag_in(n_im_reg[PW-1]), .quo(q_im), .tag_out(sgn_q[1]));

    // square root: two radicand bits per stage, padded to divider latency
    logic [SQW-1:0] rv_reg  [0:RS];
    logic [RS+1:0]  rr_reg  [0:RS];
    logic [RS:0]    rt_reg  [0:RS];
    always_comb begin
        rv_reg[0] = sq_reg;
        rr_reg[0] = '0;
        rt_reg[0] = '0;
    end
    for (genvar k = 0; k < RS; k++) begin : g_sqrt
        logic [RS+1:0] rem_sh;
        logic [RS+1:0] trial;
        always_comb begin
            rem_sh = {rr_reg[k][RS-1:0], rv_reg[k][SQW-1-2*k -: 2]};
            trial  = rem_sh - {rt_reg[k][RS-1:0], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rv_reg[k+1] <= rv_reg[k];
                if (!trial[RS+1]) begin
                    rr_reg[k+1] <= trial;
                    rt_reg[k+1] <= {rt_reg[k][RS-1:0], 1'b1};
                end else begin
                    rr_reg[k+1] <= rem_sh;
                    rt_reg[k+1] <= {rt_reg[k][RS-1:0], 1'b0};
                end
            end
        end
    end

    // delay line carrying control and the simple results alongside the divider
    typedef struct packed {
        logic                 v;
        logic [CMD_W-1:0]     c;
        logic signed [PW-1:0] sre;
        logic signed [PW-1:0] sim;
        logic                 dz;
    } dl_t;
    dl_t dl_reg [0:NW];
    always_comb begin
        dl_reg[0].v   = v2_reg;
        dl_reg[0].c   = c2_reg;
        dl_reg[0].sre = s_re_reg;
        dl_reg[0].sim = s_im_reg;
        dl_reg[0].dz  = (den_reg == '0);
    end
    for (genvar j = 0; j < NW; j++) begin : g_dl
        always_ff @(posedge aclk) begin
            if (!aresetn) dl_reg[j+1].v <= 1'b0;
            else if (adv) dl_reg[j+1].v <= dl_reg[j].v;
            if (adv) begin
                dl_reg[j+1].c   <= dl_reg[j].c;
                dl_reg[j+1].sre <= dl_reg[j].sre;
                dl_reg[j+1].sim <= dl_reg[j].sim;
                dl_reg[j+1].dz  <= dl_reg[j].dz;
            end
        end
    end
    logic [RS:0] root_d_reg [0:NW-RS];
    assign root_d_reg[0] = rt_reg[RS];
    for (genvar j = 0; j < NW-RS; j++) begin : g_rd
        always_ff @(posedge aclk) if (adv) root_d_reg[j+1] <= root_d_reg[j];
    end

    // final stage: select, sign fix, saturate
    localparam int FW = PW + FRAC_BITS + 2;
    logic signed [FW-1:0] fre, fim;
    logic [W-1:0] ore, oim;
    logic ovf_re, ovf_im, dz_f;
    dl_t e;
    assign e = dl_reg[NW];

    function automatic logic signed [FW-1:0] with_sign(logic [NW-1:0] m, logic neg);
        logic signed [FW-1:0] x;
        x = FW'(m);
        return neg ? -x : x;
    endfunction

    always_comb begin
        fre = '0;
        fim = '0;
        dz_f = 1'b0;
        case (cmd_t'(e.c)) inside
            CMD_ADD, CMD_SUB: begin
                fre = FW'(e.sre);
                fim = FW'(e.sim);
            end
            CMD_MUL: begin
                fre = FW'(e.sre >>> FRAC_BITS);
                fim = FW'(e.sim >>> FRAC_BITS);
            end
            CMD_DIV: begin
                if (e.dz) dz_f = 1'b1;
                else begin
                    fre = with_sign(q_re, sgn_q[0]);
                    fim = with_sign(q_im, sgn_q[1]);
                end
            end
            CMD_MOD: fre = FW'($unsigned(root_d_reg[NW-RS]));
            default: ;
        endcase
        ovf_re = (fre > FW'(MAXV)) || (fre < FW'(MINV));
        ovf_im = (fim > FW'(MAXV)) || (fim < FW'(MINV));
        ore = ovf_re ? (fre[FW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) : fre[W-1:0];
        oim = ovf_im ? (fim[FW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) : fim[W-1:0];
    end

    logic [2*W-1:0] out_data_reg;
    logic [1:0]     out_user_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (adv) out_valid_reg <= e.v;
        if (adv) begin
            out_data_reg <= {oim, ore};
            out_user_reg <= {dz_f, ovf_re | ovf_im};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `CAU_ASSERT_IMP(a_ready_follows_out, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `CAU_ASSERT_NXT(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CAU_ASSERT_IMP(a_flags_exclusive, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    `CAU_ASSERT_IMP(a_dz_zero, aclk, aresetn, m_tvalid && m_tuser[1], m_tdata == '0)
endmodule
`default_nettype wire

// ----- tb/tb_complex_arith_unit.sv -----
// Self-checking testbench for complex_arith_unit: directed corner items, then random traffic.
// Depends on cau_pkg and the complex_arith_unit RTL; expected results: table or local predictor.
`timescale 1ns / 1ps
module tb_complex_arith_unit
    import cau_pkg::*;
();

    localparam int DW = 16;
    localparam int FB = 8;
    localparam int LATENCY = 2*DW + FB + 5;
    localparam int N_RANDOM = 800;
    localparam longint MAX_CYCLES = 400000;
    localparam logic signed [DW-1:0] SMAX = 16'sh7fff;
    localparam logic signed [DW-1:0] SMIN = -16'sh8000;

    typedef struct packed {
        logic [2:0]             cmd;
        logic signed [DW-1:0]   a_re;
        logic signed [DW-1:0]   a_im;
        logic signed [DW-1:0]   b_re;
        logic signed [DW-1:0]   b_im;
    } operands_t;

    typedef struct packed {
        logic signed [DW-1:0]   re;
        logic signed [DW-1:0]   im;
        logic                   ovf;
        logic                   dz;
    } cresult_t;

    typedef struct {
        operands_t op;
        logic      has_exp;
        cresult_t  exp;
    } vector_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [4*DW-1:0] s_tdata = '0;
    logic [CMD_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [2*DW-1:0] m_tdata;
    logic [1:0] m_tuser;

    complex_arith_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    cresult_t expected_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_ovf = 0;
    int n_dz = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    longint cycles = 0;

    function automatic logic signed [DW-1:0] clamp(input longint v, inout logic ovf);
        if (v > longint'(SMAX)) begin
            ovf = 1'b1;
            return SMAX;
        end
        if (v < longint'(SMIN)) begin
            ovf = 1'b1;
            return SMIN;
        end
        return v[DW-1:0];
    endfunction

    function automatic longint floor_sqrt(input longint v);
        longint r = 0;
        longint b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic cresult_t complex_result(input operands_t op);
        cresult_t r = '0;
        longint ar = op.a_re;
        longint ai = op.a_im;
        longint br = op.b_re;
        longint bi = op.b_im;
        longint den;
        logic ovf = 1'b0;
        case (op.cmd)
            CMD_ADD: begin
                r.re = clamp(ar + br, ovf);
                r.im = clamp(ai + bi, ovf);
            end
            CMD_SUB: begin
                r.re = clamp(ar - br, ovf);
                r.im = clamp(ai - bi, ovf);
            end
            CMD_MUL: begin
                // >>> on signed longint floors toward minus infinity
                r.re = clamp((ar*br - ai*bi) >>> FB, ovf);
                r.im = clamp((ar*bi + ai*br) >>> FB, ovf);
            end
            CMD_DIV: begin
                den = br*br + bi*bi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    // SV integer division truncates toward zero
                    r.re = clamp(((ar*br + ai*bi) <<< FB) / den, ovf);
                    r.im = clamp(((ai*br - ar*bi) <<< FB) / den, ovf);
                end
            end
            CMD_MOD: r.re = clamp(floor_sqrt(ar*ar + ai*ai), ovf);
            default: ;
        endcase
        r.ovf = ovf;
        return r;
    endfunction

    function automatic operands_t random_operands();
        operands_t op;
        op.cmd = (($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4)));
        op.a_re = 16'($urandom);
        op.a_im = 16'($urandom);
        op.b_re = 16'($urandom);
        op.b_im = 16'($urandom);
        // mix in small magnitudes so results stay mostly in range
        if ($urandom_range(0, 1)) begin
            op.a_re = $signed(op.a_re) >>> $urandom_range(0, 12);
            op.a_im = $signed(op.a_im) >>> $urandom_range(0, 12);
            op.b_re = $signed(op.b_re) >>> $urandom_range(0, 12);
            op.b_im = $signed(op.b_im) >>> $urandom_range(0, 12);
        end
        if ($urandom_range(0, 29) == 0) begin
            op.b_re = '0;
            op.b_im = '0;
        end
        return op;
    endfunction

    task automatic send_item(input operands_t op, input logic has_exp, input cresult_t exp);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {op.b_im, op.b_re, op.a_im, op.a_re};
        s_tuser <= op.cmd;
        expected_q.push_back(has_exp ? exp : complex_result(op));
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        cresult_t got;
        cresult_t exp;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[DW-1:0], m_tdata[2*DW-1:DW], m_tuser[0], m_tuser[1]};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result re=%0d im=%0d ovf=%0b dz=%0b", $time,
                         got.re, got.im, got.ovf, got.dz);
                errors++;
            end else begin
                exp = expected_q.pop_front();
                n_checked++;
                if (got.ovf) n_ovf++;
                if (got.dz) n_dz++;
                if (got.re !== exp.re)
                    $display("%0t: res_re expected %0d got %0d", $time, exp.re, got.re);
                if (got.im !== exp.im)
                    $display("%0t: res_im expected %0d got %0d", $time, exp.im, got.im);
                if (got.ovf !== exp.ovf)
                    $display("%0t: overflow expected %0b got %0b", $time, exp.ovf, got.ovf);
                if (got.dz !== exp.dz)
                    $display("%0t: div_by_zero expected %0b got %0b", $time, exp.dz, got.dz);
                if (got !== exp) errors++;
            end
        end
    end

    always @(posedge aclk) begin
        if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        if (cycles >= MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    vector_t directed[] = '{
        // add, subtract and multiply corners; sums at the extremes saturate
        '{'{CMD_ADD, SMAX, SMIN, 16'sd1, -16'sd1}, 1'b1, '{SMAX, SMIN, 1'b1, 1'b0}},
        '{'{CMD_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
        '{'{CMD_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1, '{-16'sd2, -16'sd2, 1'b0, 1'b0}},
        '{'{CMD_SUB, SMIN, SMAX, 16'sd1, -16'sd1}, 1'b1, '{SMIN, SMAX, 1'b1, 1'b0}},
        '{'{CMD_SUB, SMAX, SMIN, SMAX, SMIN}, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
        '{'{CMD_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0}, 1'b1, '{16'sd256, 16'sd0, 1'b0, 1'b0}},
        '{'{CMD_MUL, SMIN, SMIN, SMIN, SMIN}, 1'b0, '0},
        '{'{CMD_MUL, SMAX, SMAX, SMIN, SMAX}, 1'b0, '0},
        // negative product floors toward minus infinity
        '{'{CMD_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0}, 1'b1, '{-16'sd1, 16'sd0, 1'b0, 1'b0}},
        '{'{CMD_DIV, 16'sd100, 16'sd100, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b1}},
        '{'{CMD_DIV, SMAX, SMIN, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b1}},
        '{'{CMD_DIV, 16'sd512, 16'sd0, 16'sd256, 16'sd0}, 1'b1, '{16'sd512, 16'sd0, 1'b0, 1'b0}},
        '{'{CMD_DIV, SMAX, SMAX, 16'sd1, 16'sd0}, 1'b1, '{SMAX, SMAX, 1'b1, 1'b0}},
        '{'{CMD_DIV, SMIN, SMIN, 16'sd0, -16'sd1}, 1'b0, '0},
        '{'{CMD_DIV, -16'sd7, 16'sd3, SMIN, SMAX}, 1'b0, '0},
        '{'{CMD_MOD, 16'sd768, 16'sd1024, 16'sd5, 16'sd5}, 1'b1, '{16'sd1280, 16'sd0, 1'b0, 1'b0}},
        '{'{CMD_MOD, SMIN, SMIN, 16'sd0, 16'sd0}, 1'b1, '{SMAX, 16'sd0, 1'b1, 1'b0}},
        '{'{CMD_MOD, 16'sd0, 16'sd0, SMAX, SMIN}, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
        '{'{CMD_MOD, 16'sd3, -16'sd3, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{3'd5, SMAX, SMAX, SMAX, SMAX}, 1'b1, '0},
        '{'{3'd6, SMIN, 16'sd1, 16'sd1, 16'sd1}, 1'b1, '0},
        '{'{3'd7, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1, '0}
    };

    initial begin
        int idle_pct[4] = '{0, 53, 0, 21};
        int stall_pct[4] = '{0, 0, 53, 21};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i])
            send_item(directed[i].op, directed[i].has_exp, directed[i].exp);
        s_tvalid <= 1'b0;
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            for (int k = 0; k < N_RANDOM / 4; k++)
                send_item(random_operands(), 1'b0, '0);
            s_tvalid <= 1'b0;
            // a drain without receiver stalls between phases
            send_idle_pct = 0;
            recv_stall_pct = 0;
            drain();
        end
        $display("sent %0d items, checked %0d results (%0d saturated, %0d zero divisors)",
                 n_sent, n_checked, n_ovf, n_dz);
        $display("covered all commands and unused codes across four idle/stall mixes");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
